// ===== sv/vtsd_pkg.sv =====
// Shared types, constants and helper functions for the voltage display converter.
`timescale 1ns / 1ps

package vtsd_pkg;

    localparam int MV_WIDTH   = 17;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_WIDTH  = 4 * BCD_DIGITS;
    localparam int SUM_WIDTH  = MV_WIDTH + 1;
    localparam int NUM_CELLS  = MV_WIDTH;

    localparam logic [MV_WIDTH-1:0]  WIDE_MIN  = MV_WIDTH'(9999);
    localparam logic [SUM_WIDTH-1:0] MAX_SHOWN = SUM_WIDTH'(99999);
    localparam logic [SUM_WIDTH-1:0] ROUND_ADD = SUM_WIDTH'(5);

    localparam logic [7:0] SEG_DP    = 8'h80;
    localparam logic [7:0] SEG_E     = 8'h79;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    typedef struct packed {
        logic [BCD_WIDTH-1:0] bcd;
        logic [MV_WIDTH-1:0]  bin;
        logic                 err;
        logic                 wide;
        logic                 blink;
    } t_item;

    function automatic logic [7:0] font(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    function automatic logic [BCD_WIDTH-1:0] dabble_adjust(input logic [BCD_WIDTH-1:0] bcd);
        logic [BCD_WIDTH-1:0] res;
        logic [3:0]           digit;
        res = bcd;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            digit = bcd[4*i +: 4];
            if (digit >= 4'd5) begin
                res[4*i +: 4] = digit + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/voltage_to_seven_segment_digits.sv =====
// Top level of the millivolt reading to four-digit seven-segment converter.
//
//   Channel   Signals                                       Direction
//   reading   i_valid, o_stall, i_millivolts, i_blink       request in
//   display   o_valid, i_stall, o_digit_first..o_digit_fourth  request out
//
// A request passes from acceptance to display through one rounding stage,
// one cell per bit of the 17-bit reading in the conversion chain, and one
// output stage. A new request is accepted every cycle while nothing stalls.
// Synchronous reset empties all stages. A stall holds the output and the
// stages behind it fill up; empty stages keep accepting until then.
`timescale 1ns / 1ps

module voltage_to_seven_segment_digits import vtsd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [MV_WIDTH-1:0] i_millivolts,
    input  logic                i_blink,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_digit_first,
    output logic [7:0]          o_digit_second,
    output logic [7:0]          o_digit_third,
    output logic [7:0]          o_digit_fourth
);

    logic  chain_valid [NUM_CELLS+1];
    logic  chain_stall [NUM_CELLS+1];
    t_item chain_item  [NUM_CELLS+1];

    vtsd_round u_round (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_millivolts (i_millivolts),
        .i_blink      (i_blink),
        .o_valid      (chain_valid[0]),
        .i_stall      (chain_stall[0]),
        .o_item       (chain_item[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        vtsd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_stall (chain_stall[k]),
            .i_item  (chain_item[k]),
            .o_valid (chain_valid[k+1]),
            .i_stall (chain_stall[k+1]),
            .o_item  (chain_item[k+1])
        );
    end

    vtsd_fmt u_fmt (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (chain_valid[NUM_CELLS]),
        .o_stall        (chain_stall[NUM_CELLS]),
        .i_item         (chain_item[NUM_CELLS]),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digit_first  (o_digit_first),
        .o_digit_second (o_digit_second),
        .o_digit_third  (o_digit_third),
        .o_digit_fourth (o_digit_fourth)
    );

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid right after reset.");

    a_one_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_digit_first != SEG_E |-> o_digit_first[7] != o_digit_second[7])
        else $error("Exactly one of the first two digits must carry the point.");

    a_third_no_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_digit_third[7])
        else $error("Third digit never carries a point.");

    a_error_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_digit_first == SEG_E |->
            o_digit_second == SEG_BLANK && o_digit_third == SEG_BLANK &&
            o_digit_fourth[6:0] == 7'd0)
        else $error("Error display must blank the other digits.");
`endif

endmodule

// ===== sv/vtsd_round.sv =====
// Entry stage that rounds wide readings and flags readings that cannot be shown.
`timescale 1ns / 1ps

module vtsd_round import vtsd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [MV_WIDTH-1:0] i_millivolts,
    input  logic                i_blink,
    output logic                o_valid,
    input  logic                i_stall,
    output t_item               o_item
);

    logic                 r_valid;
    t_item                r_item;
    t_item                n_item;
    logic                 n_wide;
    logic [SUM_WIDTH-1:0] n_sum;

    always_comb begin
        n_wide       = i_millivolts > WIDE_MIN;
        n_sum        = {1'b0, i_millivolts} + (n_wide ? ROUND_ADD : '0);
        n_item.bcd   = '0;
        n_item.bin   = n_sum[MV_WIDTH-1:0];
        n_item.err   = n_sum > MAX_SHOWN;
        n_item.wide  = n_wide;
        n_item.blink = i_blink;
    end

    assign o_stall = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== sv/vtsd_cell.sv =====
// One shift-and-add-three cell of the binary to decimal conversion chain.
`timescale 1ns / 1ps

module vtsd_cell import vtsd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_stall,
    output t_item o_item
);

    logic                 r_valid;
    t_item                r_item;
    t_item                n_item;
    logic [BCD_WIDTH-1:0] n_adj;

    always_comb begin
        n_item     = i_item;
        n_adj      = dabble_adjust(i_item.bcd);
        n_item.bcd = {n_adj[BCD_WIDTH-2:0], i_item.bin[MV_WIDTH-1]};
        n_item.bin = {i_item.bin[MV_WIDTH-2:0], 1'b0};
    end

    assign o_stall = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== sv/vtsd_fmt.sv =====
// Output stage that maps decimal digits to segment patterns and holds the result.
`timescale 1ns / 1ps

module vtsd_fmt import vtsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_item      i_item,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_digit_first,
    output logic [7:0] o_digit_second,
    output logic [7:0] o_digit_third,
    output logic [7:0] o_digit_fourth
);

    logic       r_valid;
    logic [7:0] r_d0;
    logic [7:0] r_d1;
    logic [7:0] r_d2;
    logic [7:0] r_d3;
    logic [7:0] n_d0;
    logic [7:0] n_d1;
    logic [7:0] n_d2;
    logic [7:0] n_d3;

    always_comb begin
        if (i_item.err) begin
            n_d0 = SEG_E;
            n_d1 = SEG_BLANK;
            n_d2 = SEG_BLANK;
            n_d3 = SEG_BLANK;
        end else if (i_item.wide) begin
            n_d0 = font(i_item.bcd[19:16]);
            n_d1 = font(i_item.bcd[15:12]) | SEG_DP;
            n_d2 = font(i_item.bcd[11:8]);
            n_d3 = font(i_item.bcd[7:4]);
        end else begin
            n_d0 = font(i_item.bcd[15:12]) | SEG_DP;
            n_d1 = font(i_item.bcd[11:8]);
            n_d2 = font(i_item.bcd[7:4]);
            n_d3 = font(i_item.bcd[3:0]);
        end
        if (i_item.blink) begin
            n_d3 = n_d3 | SEG_DP;
        end
    end

    assign o_stall        = r_valid & i_stall;
    assign o_valid        = r_valid;
    assign o_digit_first  = r_d0;
    assign o_digit_second = r_d1;
    assign o_digit_third  = r_d2;
    assign o_digit_fourth = r_d3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_d0 <= n_d0;
            r_d1 <= n_d1;
            r_d2 <= n_d2;
            r_d3 <= n_d3;
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the millivolt reading to seven-segment digit converter.
`timescale 1ns / 1ps

module testbench;
    import vtsd_pkg::*;

    localparam int unsigned NARROW_TOP = 9999;
    localparam int unsigned SHOWN_TOP  = 99999;
    localparam int unsigned HALF_TEN   = 5;
    localparam int unsigned READING_MAX = (1 << MV_WIDTH) - 1;
    localparam int          LATENCY    = 19;
    localparam int          MAX_REPORTS = 10;

    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    localparam int unsigned CORNER_MV [22] = '{
        0, 1, 9, 10, 99, 100, 999, 1000, 5005, 9999, 10000, 10004, 10005,
        10994, 10995, 12345, 67890, 99994, 99995, 99999, 100000, 131071
    };

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
        logic [7:0] fourth;
    } t_display;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [MV_WIDTH-1:0] i_millivolts = '0;
    logic                i_blink = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [7:0]          o_digit_first;
    logic [7:0]          o_digit_second;
    logic [7:0]          o_digit_third;
    logic [7:0]          o_digit_fourth;

    t_display pending_displays[$];
    int       mismatch_count = 0;
    int       burst_left = 0;
    bit       gaps_enabled = 1'b1;
    int       stall_mode = 0;
    int       stall_phase = 0;

    voltage_to_seven_segment_digits DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_millivolts   (i_millivolts),
        .i_blink        (i_blink),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digit_first  (o_digit_first),
        .o_digit_second (o_digit_second),
        .o_digit_third  (o_digit_third),
        .o_digit_fourth (o_digit_fourth)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [7:0] glyph_at(int unsigned value, int unsigned place);
        return DIGIT_GLYPH[4'((value / place) % 10)];
    endfunction

    function automatic t_display predict_display(logic [MV_WIDTH-1:0] mv, logic blink);
        t_display    d;
        int unsigned v;
        v = 32'(mv);
        if (v > NARROW_TOP) v += HALF_TEN;
        if (v > SHOWN_TOP) begin
            d.first  = SEG_E;
            d.second = SEG_BLANK;
            d.third  = SEG_BLANK;
            d.fourth = SEG_BLANK;
        end else if (v > NARROW_TOP) begin
            d.first  = glyph_at(v, 10000);
            d.second = glyph_at(v, 1000) | SEG_DP;
            d.third  = glyph_at(v, 100);
            d.fourth = glyph_at(v, 10);
        end else begin
            d.first  = glyph_at(v, 1000) | SEG_DP;
            d.second = glyph_at(v, 100);
            d.third  = glyph_at(v, 10);
            d.fourth = glyph_at(v, 1);
        end
        if (blink) d.fourth = d.fourth | SEG_DP;
        return d;
    endfunction

    // The receiver switches between randomly chosen stall patterns.
    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_phase <= $urandom_range(50, 300);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= (stall_phase[3:0] >= 4'd10);
        endcase
    end

    always @(posedge i_clk) begin
        t_display want;
        t_display got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_digit_first, o_digit_second, o_digit_third, o_digit_fourth};
            if (pending_displays.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: display %h %h %h %h with no request outstanding",
                             got.first, got.second, got.third, got.fourth);
            end else begin
                want = pending_displays.pop_front();
                if (got.first !== want.first || got.second !== want.second ||
                    got.third !== want.third || got.fourth !== want.fourth) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("ERROR: expected %h %h %h %h, got %h %h %h %h",
                                 want.first, want.second, want.third, want.fourth,
                                 got.first, got.second, got.third, got.fourth);
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the request is taken, or after an idle gap that follows it.
    task automatic send_reading(input logic [MV_WIDTH-1:0] mv, input logic blink);
        i_valid      <= 1'b1;
        i_millivolts <= mv;
        i_blink      <= blink;
        do @(posedge i_clk); while (o_stall);
        pending_displays.push_back(predict_display(mv, blink));
        if (gaps_enabled) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if ($urandom_range(0, 2) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_for_displays();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_displays.size() != 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic test_corner_readings();
        foreach (CORNER_MV[i]) send_reading(MV_WIDTH'(CORNER_MV[i]), i[0]);
        send_reading(MV_WIDTH'(READING_MAX), 1'b0);
        send_reading('0, 1'b1);
    endtask

    task automatic test_rounding_boundaries();
        repeat (80) begin
            if ($urandom_range(0, 1))
                send_reading(MV_WIDTH'($urandom_range(SHOWN_TOP - 20, SHOWN_TOP + 20)),
                             1'($urandom_range(0, 1)));
            else
                send_reading(MV_WIDTH'($urandom_range(NARROW_TOP - 20, NARROW_TOP + 20)),
                             1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_readings();
        int unsigned mv;
        repeat (400) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mv = $urandom_range(0, NARROW_TOP);
                4, 5, 6, 7: mv = $urandom_range(NARROW_TOP + 1, SHOWN_TOP);
                8:          mv = (($urandom_range(0, SHOWN_TOP / 10)) * 10) + HALF_TEN
                                 - $urandom_range(0, 1);
                default:    mv = $urandom_range(0, READING_MAX);
            endcase
            send_reading(MV_WIDTH'(mv), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_back_to_back();
        gaps_enabled = 1'b0;
        repeat (60) send_reading(MV_WIDTH'($urandom_range(0, READING_MAX)),
                                 1'($urandom_range(0, 1)));
        gaps_enabled = 1'b1;
    endtask

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_readings();
        wait_for_displays();
        test_rounding_boundaries();
        test_back_to_back();
        wait_for_displays();
        test_random_readings();
        test_back_to_back();
        wait_for_displays();
        if (mismatch_count == 0 && pending_displays.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
